/* hw/rtl/id3fw_pkg.sv */
// ----------------------------------------------------------------------------
// id3fw_pkg - shared types and constants for the ID3v2 frame walker
// Holds the request and result structs, the walk phase encoding and the
// region, class, field and stop codes.
// ----------------------------------------------------------------------------
package id3fw_pkg;

    // One input request: a file byte and the start-of-file mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } id3fw_in_t;

    // One result per input byte
    typedef struct packed {
        logic [2:0]  region;
        logic [1:0]  frame_class;
        logic [2:0]  text_field;
        logic [31:0] frame_ident;
        logic [27:0] payload_offset;
        logic        last_of_frame;
        logic [1:0]  stop_reason;
        logic [7:0]  tag_version;
    } id3fw_out_t;

    // Walk phase, one-hot
    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_EXT     = 7'b0000010,
        PH_FHDR    = 7'b0000100,
        PH_PAYLOAD = 7'b0001000,
        PH_SKIP    = 7'b0010000,
        PH_AFTER   = 7'b0100000,
        PH_NOTAG   = 7'b1000000
    } id3fw_phase_t;

    // Region codes
    localparam logic [2:0] REG_TAGHDR  = 3'd0;
    localparam logic [2:0] REG_EXTHDR  = 3'd1;
    localparam logic [2:0] REG_FRMHDR  = 3'd2;
    localparam logic [2:0] REG_PAYLOAD = 3'd3;
    localparam logic [2:0] REG_SKIP    = 3'd4;
    localparam logic [2:0] REG_AFTER   = 3'd5;
    localparam logic [2:0] REG_NOTAG   = 3'd6;

    // Frame classes
    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_TEXT  = 2'd1;
    localparam logic [1:0] CLS_TXXX  = 2'd2;
    localparam logic [1:0] CLS_APIC  = 2'd3;

    // Text fields
    localparam logic [2:0] FLD_NONE   = 3'd0;
    localparam logic [2:0] FLD_TITLE  = 3'd1;
    localparam logic [2:0] FLD_ARTIST = 3'd2;
    localparam logic [2:0] FLD_ALBUM  = 3'd3;
    localparam logic [2:0] FLD_YEAR   = 3'd4;
    localparam logic [2:0] FLD_GENRE  = 3'd5;
    localparam logic [2:0] FLD_TRACK  = 3'd6;
    localparam logic [2:0] FLD_BPM    = 3'd7;

    // Stop reasons
    localparam logic [1:0] STOP_NONE    = 2'd0;
    localparam logic [1:0] STOP_PADDING = 2'd1;
    localparam logic [1:0] STOP_BADSIZE = 2'd2;

    // Tag header magic and limits
    localparam logic [7:0] MAGIC_0   = 8'h49;
    localparam logic [7:0] MAGIC_1   = 8'h44;
    localparam logic [7:0] MAGIC_2   = 8'h33;
    localparam logic [7:0] VER_V22   = 8'd2;
    localparam logic [7:0] VER_V23   = 8'd3;
    localparam logic [7:0] VER_V24   = 8'd4;
    localparam logic [6:0] SIZE_MASK = 7'h7F;

endpackage

/* hw/rtl/id3fw_classify.sv */
// ----------------------------------------------------------------------------
// id3fw_classify - frame ID mapping and classing
// Maps a v2.2 three-character ID onto a four-character name and classes the
// frame as text, TXXX or APIC, with the text field it carries.
// ----------------------------------------------------------------------------
module id3fw_classify
    import id3fw_pkg::*;
(
    input  logic [31:0] ident,
    input  logic        is_v22,
    output logic [31:0] mapped_ident,
    output logic [1:0]  frame_class,
    output logic [2:0]  text_field
);

    localparam logic [23:0] ID22_TT2 = "TT2";
    localparam logic [23:0] ID22_TP1 = "TP1";
    localparam logic [23:0] ID22_TAL = "TAL";
    localparam logic [23:0] ID22_TYE = "TYE";
    localparam logic [23:0] ID22_TCO = "TCO";
    localparam logic [23:0] ID22_TRK = "TRK";
    localparam logic [23:0] ID22_TBP = "TBP";
    localparam logic [23:0] ID22_TXX = "TXX";
    localparam logic [23:0] ID22_PIC = "PIC";

    localparam logic [31:0] ID_TIT2 = "TIT2";
    localparam logic [31:0] ID_TPE1 = "TPE1";
    localparam logic [31:0] ID_TALB = "TALB";
    localparam logic [31:0] ID_TDRC = "TDRC";
    localparam logic [31:0] ID_TYER = "TYER";
    localparam logic [31:0] ID_TCON = "TCON";
    localparam logic [31:0] ID_TRCK = "TRCK";
    localparam logic [31:0] ID_TBPM = "TBPM";
    localparam logic [31:0] ID_TXXX = "TXXX";
    localparam logic [31:0] ID_APIC = "APIC";
    localparam logic [7:0]  CHAR_T  = "T";

    logic [31:0] v22_ident;

    // Map a v2.2 ID; an unknown one keeps its three characters on top
    always_comb
    begin
        case (ident[23:0])
            ID22_TT2: v22_ident = ID_TIT2;
            ID22_TP1: v22_ident = ID_TPE1;
            ID22_TAL: v22_ident = ID_TALB;
            ID22_TYE: v22_ident = ID_TDRC;
            ID22_TCO: v22_ident = ID_TCON;
            ID22_TRK: v22_ident = ID_TRCK;
            ID22_TBP: v22_ident = ID_TBPM;
            ID22_TXX: v22_ident = ID_TXXX;
            ID22_PIC: v22_ident = ID_APIC;
            default:  v22_ident = {ident[23:0], 8'd0};
        endcase
    end

    assign mapped_ident = is_v22 ? v22_ident : ident;

    // Class the frame and pick out the text field
    always_comb
    begin
        frame_class = CLS_OTHER;
        text_field  = FLD_NONE;
        if (mapped_ident == ID_TXXX)
        begin
            frame_class = CLS_TXXX;
        end
        else if (mapped_ident == ID_APIC)
        begin
            frame_class = CLS_APIC;
        end
        else if (mapped_ident[31:24] == CHAR_T)
        begin
            frame_class = CLS_TEXT;
            case (mapped_ident)
                ID_TIT2: text_field = FLD_TITLE;
                ID_TPE1: text_field = FLD_ARTIST;
                ID_TALB: text_field = FLD_ALBUM;
                ID_TDRC: text_field = FLD_YEAR;
                ID_TYER: text_field = FLD_YEAR;
                ID_TCON: text_field = FLD_GENRE;
                ID_TRCK: text_field = FLD_TRACK;
                ID_TBPM: text_field = FLD_BPM;
                default: text_field = FLD_NONE;
            endcase
        end
    end

endmodule

/* hw/rtl/id3fw_walker.sv */
// ----------------------------------------------------------------------------
// id3fw_walker - per-byte tag walk state and result logic
// Holds the walk state, advances it by one file byte when stepped and
// forms the result for that byte.
// ----------------------------------------------------------------------------
module id3fw_walker
    import id3fw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  id3fw_in_t  item,
    output id3fw_out_t result
);

    id3fw_phase_t phase_reg, phase_next;
    logic [3:0]   header_count_reg, header_count_next;
    logic [7:0]   version_reg, version_next;
    logic         ext_flag_reg, ext_flag_next;
    logic [27:0]  tag_length_reg, tag_length_next;
    logic [27:0]  body_pos_reg, body_pos_next;
    logic [31:0]  ext_left_reg, ext_left_next;
    logic [31:0]  ident_shift_reg, ident_shift_next;
    logic [31:0]  size_shift_reg, size_shift_next;
    logic [3:0]   hbi_reg, hbi_next;
    logic [27:0]  frame_left_reg, frame_left_next;
    logic [1:0]   class_reg, class_next;
    logic [2:0]   field_reg, field_next;
    logic [27:0]  offset_reg, offset_next;
    logic [1:0]   stop_reg, stop_next;

    // Working view of the state: a start-of-file byte sees a cleared walk
    id3fw_phase_t c_phase;
    logic [3:0]   c_hcnt;
    logic [7:0]   c_version;
    logic         c_ext_flag;
    logic [27:0]  c_tag_len;
    logic [27:0]  c_body_pos;
    logic [31:0]  c_ext_left;
    logic [31:0]  c_ident;
    logic [31:0]  c_size;
    logic [3:0]   c_hbi;
    logic [27:0]  c_frame_left;
    logic [1:0]   c_class;
    logic [2:0]   c_field;
    logic [27:0]  c_offset;
    logic [1:0]   c_stop;

    logic [7:0]   b;
    logic         v22;
    logic         v24;
    logic [31:0]  size_add;
    logic [31:0]  fh_size;
    logic [3:0]   id_len;
    logic [3:0]   hdr_len;
    logic [3:0]   min_room;
    logic [27:0]  room;
    logic [27:0]  remaining;
    logic [3:0]   hbi_inc;
    logic [27:0]  body_inc;
    logic [27:0]  tl_shift;
    logic         magic_bad;
    logic         in_body;
    logic [31:0]  mapped_ident;
    logic [1:0]   map_class;
    logic [2:0]   map_field;

    assign b            = item.data_byte;
    assign c_phase      = item.first ? PH_HEADER : phase_reg;
    assign c_hcnt       = item.first ? 4'd0  : header_count_reg;
    assign c_version    = item.first ? 8'd0  : version_reg;
    assign c_ext_flag   = item.first ? 1'b0  : ext_flag_reg;
    assign c_tag_len    = item.first ? 28'd0 : tag_length_reg;
    assign c_body_pos   = item.first ? 28'd0 : body_pos_reg;
    assign c_ext_left   = item.first ? 32'd0 : ext_left_reg;
    assign c_ident      = item.first ? 32'd0 : ident_shift_reg;
    assign c_size       = item.first ? 32'd0 : size_shift_reg;
    assign c_hbi        = item.first ? 4'd0  : hbi_reg;
    assign c_frame_left = item.first ? 28'd0 : frame_left_reg;
    assign c_class      = item.first ? CLS_OTHER : class_reg;
    assign c_field      = item.first ? FLD_NONE  : field_reg;
    assign c_offset     = item.first ? 28'd0 : offset_reg;
    assign c_stop       = item.first ? STOP_NONE : stop_reg;

    // Size accumulation: synchsafe for v2.4, plain bytes otherwise
    assign v22      = (c_version == VER_V22);
    assign v24      = (c_version == VER_V24);
    assign size_add = v24 ? {c_size[24:0], b[6:0]} : {c_size[23:0], b};
    assign fh_size  = v22 ? {8'd0, c_size[15:0], b} : size_add;
    assign id_len   = v22 ? 4'd3 : 4'd4;
    assign hdr_len  = v22 ? 4'd6 : 4'd10;
    assign min_room = v22 ? 4'd6 : 4'd8;

    // Tag room left for the frame header and for the frame payload
    assign room      = c_tag_len - c_body_pos;
    assign remaining = c_tag_len - body_inc;
    assign hbi_inc   = c_hbi + 4'd1;
    assign body_inc  = c_body_pos + 28'd1;
    assign tl_shift  = {c_tag_len[20:0], b[6:0] & SIZE_MASK};

    assign magic_bad = ((c_hcnt == 4'd0) && (b != MAGIC_0))
                    || ((c_hcnt == 4'd1) && (b != MAGIC_1))
                    || ((c_hcnt == 4'd2) && (b != MAGIC_2));

    assign in_body = (c_phase inside {PH_EXT, PH_FHDR, PH_PAYLOAD, PH_SKIP});

    id3fw_classify u_classify (
        .ident        (c_ident),
        .is_v22       (v22),
        .mapped_ident (mapped_ident),
        .frame_class  (map_class),
        .text_field   (map_field)
    );

    // Header byte counter step
    function automatic logic [3:0] hbi_from_count(input logic [3:0] count);
        hbi_from_count = count + 4'd1;
    endfunction

    // Advance the walk by one byte and form its result
    always_comb
    begin
        phase_next        = c_phase;
        header_count_next = c_hcnt;
        version_next      = c_version;
        ext_flag_next     = c_ext_flag;
        tag_length_next   = c_tag_len;
        body_pos_next     = c_body_pos;
        ext_left_next     = c_ext_left;
        ident_shift_next  = c_ident;
        size_shift_next   = c_size;
        hbi_next          = c_hbi;
        frame_left_next   = c_frame_left;
        class_next        = c_class;
        field_next        = c_field;
        offset_next       = c_offset;
        stop_next         = c_stop;

        result                = '0;
        result.region         = REG_NOTAG;

        case (c_phase)
            PH_HEADER:
            begin
                if (magic_bad)
                begin
                    phase_next    = PH_NOTAG;
                    result.region = REG_NOTAG;
                end
                else
                begin
                    result.region     = REG_TAGHDR;
                    header_count_next = hbi_from_count(c_hcnt);
                    if (c_hcnt == 4'd3)
                    begin
                        version_next = b;
                    end
                    if (c_hcnt == 4'd5)
                    begin
                        ext_flag_next = b[6];
                    end
                    if (c_hcnt >= 4'd6)
                    begin
                        tag_length_next = tl_shift;
                    end
                    if (c_hcnt >= 4'd9)
                    begin
                        body_pos_next   = '0;
                        hbi_next        = '0;
                        size_shift_next = '0;
                        if (tl_shift == 28'd0)
                        begin
                            phase_next = PH_AFTER;
                        end
                        else if (c_ext_flag && (c_version >= VER_V23)
                                 && (tl_shift >= 28'd4))
                        begin
                            phase_next = PH_EXT;
                        end
                        else
                        begin
                            phase_next       = PH_FHDR;
                            ident_shift_next = '0;
                        end
                    end
                end
            end

            PH_EXT:
            begin
                result.region = REG_EXTHDR;
                if (c_hbi < 4'd4)
                begin
                    size_shift_next = size_add;
                    hbi_next        = hbi_inc;
                    if (hbi_inc == 4'd4)
                    begin
                        if (v24)
                        begin
                            ext_left_next = (size_add > 32'd4) ? size_add - 32'd4 : 32'd0;
                        end
                        else
                        begin
                            ext_left_next = size_add;
                        end
                        if (ext_left_next == 32'd0)
                        begin
                            phase_next       = PH_FHDR;
                            hbi_next         = '0;
                            ident_shift_next = '0;
                            size_shift_next  = '0;
                        end
                    end
                end
                else
                begin
                    ext_left_next = c_ext_left - 32'd1;
                    if (c_ext_left == 32'd1)
                    begin
                        phase_next       = PH_FHDR;
                        hbi_next         = '0;
                        ident_shift_next = '0;
                        size_shift_next  = '0;
                    end
                end
            end

            PH_FHDR:
            begin
                if ((c_hbi == 4'd0) && (room < {24'd0, min_room}))
                begin
                    phase_next    = PH_SKIP;
                    result.region = REG_SKIP;
                end
                else if ((c_hbi == 4'd0) && (b == 8'd0))
                begin
                    stop_next     = STOP_PADDING;
                    phase_next    = PH_SKIP;
                    result.region = REG_SKIP;
                end
                else
                begin
                    result.region = REG_FRMHDR;
                    if (c_hbi < id_len)
                    begin
                        ident_shift_next = {c_ident[23:0], b};
                    end
                    else if (c_hbi < min_room)
                    begin
                        size_shift_next = fh_size;
                    end
                    hbi_next = hbi_inc;
                    if (hbi_inc >= hdr_len)
                    begin
                        if ((size_shift_next == 32'd0)
                            || (size_shift_next > {4'd0, remaining}))
                        begin
                            stop_next  = STOP_BADSIZE;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            ident_shift_next = mapped_ident;
                            class_next       = map_class;
                            field_next       = map_field;
                            frame_left_next  = size_shift_next[27:0];
                            offset_next      = '0;
                            phase_next       = PH_PAYLOAD;
                        end
                    end
                end
            end

            PH_PAYLOAD:
            begin
                result.region         = REG_PAYLOAD;
                result.frame_class    = c_class;
                result.text_field     = c_field;
                result.frame_ident    = c_ident;
                result.payload_offset = c_offset;
                result.last_of_frame  = (c_frame_left == 28'd1);
                frame_left_next       = c_frame_left - 28'd1;
                offset_next           = c_offset + 28'd1;
                if (c_frame_left == 28'd1)
                begin
                    phase_next       = PH_FHDR;
                    hbi_next         = '0;
                    ident_shift_next = '0;
                    size_shift_next  = '0;
                end
            end

            PH_SKIP:
            begin
                result.region = REG_SKIP;
            end

            PH_AFTER:
            begin
                result.region = REG_AFTER;
            end

            default:
            begin
                result.region = REG_NOTAG;
            end
        endcase

        // Count body bytes and close the walk at the tag end
        if (in_body)
        begin
            body_pos_next = body_inc;
            if (body_inc >= c_tag_len)
            begin
                if ((phase_next == PH_FHDR) && (hbi_next != 4'd0)
                    && (stop_next == STOP_NONE))
                begin
                    stop_next = STOP_BADSIZE;
                end
                phase_next = PH_AFTER;
            end
        end

        result.stop_reason = stop_next;
        result.tag_version = version_next;
    end

    // Hold the walk state; advance only on a step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_NOTAG;
            header_count_reg <= '0;
            version_reg      <= '0;
            ext_flag_reg     <= 1'b0;
            tag_length_reg   <= '0;
            body_pos_reg     <= '0;
            ext_left_reg     <= '0;
            ident_shift_reg  <= '0;
            size_shift_reg   <= '0;
            hbi_reg          <= '0;
            frame_left_reg   <= '0;
            class_reg        <= CLS_OTHER;
            field_reg        <= FLD_NONE;
            offset_reg       <= '0;
            stop_reg         <= STOP_NONE;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            version_reg      <= version_next;
            ext_flag_reg     <= ext_flag_next;
            tag_length_reg   <= tag_length_next;
            body_pos_reg     <= body_pos_next;
            ext_left_reg     <= ext_left_next;
            ident_shift_reg  <= ident_shift_next;
            size_shift_reg   <= size_shift_next;
            hbi_reg          <= hbi_next;
            frame_left_reg   <= frame_left_next;
            class_reg        <= class_next;
            field_reg        <= field_next;
            offset_reg       <= offset_next;
            stop_reg         <= stop_next;
        end
    end

endmodule

/* hw/rtl/id3v2_frame_walker_core.sv */
// ----------------------------------------------------------------------------
// id3v2_frame_walker_core - byte-serial ID3v2 tag and frame walker
// Classes every byte of a file as tag header, extended header, frame
// header, frame payload, skipped, after the tag or no tag.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel: byte_valid / byte_stall / byte_data. A request is taken at
//   a rising edge with byte_valid high and byte_stall low. Set first on the
//   first byte of each file; it restarts the parse.
//   Result channel: res_valid / res_stall / res_data, one result per byte,
//   in byte order.
//   Path: a byte taken is held in the input register, then walked into the
//   result register, and is offered from then on.
//   Throughput: one byte per cycle while res_stall is low; the per-byte state
//   update sits between the input register and the result register.
//   Stall: while res_stall holds a result, the byte in the input register
//   waits and byte_stall rises; the walk state does not move.
//   Reset: both registers empty, the walk stands in the no-tag state until a
//   byte marked first arrives.
// ----------------------------------------------------------------------------
module id3v2_frame_walker_core
    import id3fw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  id3fw_in_t  byte_data,
    output logic       res_valid,
    input  logic       res_stall,
    output id3fw_out_t res_data
);

    logic       s1_valid_reg, s1_valid_next;
    id3fw_in_t  s1_item_reg;
    logic       res_valid_reg, res_valid_next;
    id3fw_out_t res_item_reg;
    id3fw_out_t walk_result;
    logic       advance;
    logic       take;

    // Move the held byte on when the result register is free or draining
    assign advance    = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign byte_stall = s1_valid_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    id3fw_walker u_walker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (s1_item_reg),
        .result (walk_result)
    );

    // Track occupancy of both registers
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Capture request and result payloads
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= byte_data;
        end
        if (advance)
        begin
            res_item_reg <= walk_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_item_reg;

    // Stall only when a byte is held behind a full result register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (s1_valid_reg && res_valid_reg && res_stall))
        else $error("byte stall without a blocked result");

    // Frame fields stay clear outside payload bytes
    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.region != REG_PAYLOAD)) |->
        ((res_data.frame_class == CLS_OTHER) && (res_data.text_field == FLD_NONE)
         && (res_data.frame_ident == 32'd0) && (res_data.payload_offset == 28'd0)
         && !res_data.last_of_frame))
        else $error("frame fields set outside payload");

    // No payload once the frame walk has stopped
    a_payload_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.region == REG_PAYLOAD)) |->
        (res_data.stop_reason == STOP_NONE))
        else $error("payload byte after the walk stopped");

endmodule

/* tb/sv/id3fw_walk_sb_pkg.sv */
// ----------------------------------------------------------------------------
// id3fw_walk_sb_pkg - scoreboard for the ID3v2 frame walker testbench
// Holds a walker of its own that follows every byte request accepted by the
// block, keeps the classification it expects for each byte in order, and
// compares each result from the block with the oldest expectation.
// ----------------------------------------------------------------------------
package id3fw_walk_sb_pkg;

    import id3fw_pkg::*;

    class id3_walk_scoreboard;

        id3fw_out_t   walk_results_q[$];
        int unsigned  fail_count;
        int unsigned  checked;

        // Walker state, kept at the widths of the block except frame_left, which is wider
        id3fw_phase_t phase;
        logic [3:0]   hdr_count;
        logic [7:0]   version;
        logic         ext_present;
        logic [27:0]  tag_len;
        logic [27:0]  body_pos;
        logic [31:0]  ext_left;
        logic [31:0]  ident_acc;
        logic [31:0]  size_acc;
        logic [3:0]   fhdr_idx;
        logic [31:0]  frame_left;
        logic [1:0]   cls;
        logic [2:0]   fld;
        logic [27:0]  offset;
        logic [1:0]   stop;

        function new();
            fail_count = 0;
            checked    = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            phase       = PH_NOTAG;
            hdr_count   = '0;
            version     = '0;
            ext_present = 1'b0;
            tag_len     = '0;
            body_pos    = '0;
            ext_left    = '0;
            ident_acc   = '0;
            size_acc    = '0;
            fhdr_idx    = '0;
            frame_left  = '0;
            cls         = CLS_OTHER;
            fld         = FLD_NONE;
            offset      = '0;
            stop        = STOP_NONE;
        endfunction

        // Shift in one size byte: seven bits for v2.4, eight otherwise
        function logic [31:0] size_byte(logic [31:0] acc, logic [7:0] b);
            if (version == VER_V24)
                return {acc[24:0], b[6:0]};
            return {acc[23:0], b};
        endfunction

        function void start_header();
            phase     = PH_FHDR;
            fhdr_idx  = '0;
            ident_acc = '0;
            size_acc  = '0;
        endfunction

        // Map a three-character v2.2 ID to its four-character name
        function logic [31:0] map_v22(logic [23:0] id3);
            case (id3)
                "TT2":   return "TIT2";
                "TP1":   return "TPE1";
                "TAL":   return "TALB";
                "TYE":   return "TDRC";
                "TCO":   return "TCON";
                "TRK":   return "TRCK";
                "TBP":   return "TBPM";
                "TXX":   return "TXXX";
                "PIC":   return "APIC";
                default: return {id3, 8'h00};
            endcase
        endfunction

        function void classify();
            logic [31:0] id;
            id = ident_acc;
            if (version == VER_V22)
                id = map_v22(ident_acc[23:0]);
            ident_acc = id;
            cls       = CLS_OTHER;
            fld       = FLD_NONE;
            if (id == "TXXX")
                cls = CLS_TXXX;
            else if (id == "APIC")
                cls = CLS_APIC;
            else if (id[31:24] == "T")
            begin
                cls = CLS_TEXT;
                case (id)
                    "TIT2":         fld = FLD_TITLE;
                    "TPE1":         fld = FLD_ARTIST;
                    "TALB":         fld = FLD_ALBUM;
                    "TDRC", "TYER": fld = FLD_YEAR;
                    "TCON":         fld = FLD_GENRE;
                    "TRCK":         fld = FLD_TRACK;
                    "TBPM":         fld = FLD_BPM;
                    default:        fld = FLD_NONE;
                endcase
            end
        endfunction

        // Advance the walk by one byte and return its classification
        function id3fw_out_t walk_byte(logic [7:0] b, logic mark);
            id3fw_out_t  r;
            logic        in_body;
            logic        v22;
            int unsigned idn;
            int unsigned hlen;
            logic [3:0]  idx;
            logic [31:0] room;

            r        = '0;
            r.region = REG_NOTAG;
            if (mark)
            begin
                clear_walk();
                phase = PH_HEADER;
            end
            in_body = (phase == PH_EXT) || (phase == PH_FHDR) ||
                      (phase == PH_PAYLOAD) || (phase == PH_SKIP);

            case (phase)
                PH_HEADER:
                begin
                    r.region = REG_TAGHDR;
                    if ((hdr_count == 0 && b != MAGIC_0) || (hdr_count == 1 && b != MAGIC_1) ||
                        (hdr_count == 2 && b != MAGIC_2))
                    begin
                        phase    = PH_NOTAG;
                        r.region = REG_NOTAG;
                    end
                    else
                    begin
                        if (hdr_count == 3)
                            version = b;
                        if (hdr_count == 5)
                            ext_present = b[6];
                        if (hdr_count >= 6)
                            tag_len = {tag_len[20:0], b[6:0]};
                        if (hdr_count >= 9)
                        begin
                            body_pos = '0;
                            fhdr_idx = '0;
                            size_acc = '0;
                            if (tag_len == 0)
                                phase = PH_AFTER;
                            else if (ext_present && version >= VER_V23 && tag_len >= 4)
                                phase = PH_EXT;
                            else
                                start_header();
                        end
                        hdr_count = hdr_count + 4'd1;
                    end
                end
                PH_EXT:
                begin
                    r.region = REG_EXTHDR;
                    if (fhdr_idx < 4)
                    begin
                        size_acc = size_byte(size_acc, b);
                        fhdr_idx = fhdr_idx + 4'd1;
                        if (fhdr_idx == 4)
                        begin
                            if (version == VER_V24)
                                ext_left = (size_acc > 4) ? size_acc - 32'd4 : 32'd0;
                            else
                                ext_left = size_acc;
                            if (ext_left == 0)
                                start_header();
                        end
                    end
                    else
                    begin
                        ext_left = ext_left - 32'd1;
                        if (ext_left == 0)
                            start_header();
                    end
                end
                PH_FHDR:
                begin
                    v22  = (version == VER_V22);
                    idn  = v22 ? 3 : 4;
                    hlen = v22 ? 6 : 10;
                    idx  = fhdr_idx;
                    if (idx == 0 && (32'(tag_len) - 32'(body_pos)) < 2 * idn)
                    begin
                        // too little room left for an ID and a size
                        phase    = PH_SKIP;
                        r.region = REG_SKIP;
                    end
                    else if (idx == 0 && b == 8'h00)
                    begin
                        stop     = STOP_PADDING;
                        phase    = PH_SKIP;
                        r.region = REG_SKIP;
                    end
                    else
                    begin
                        r.region = REG_FRMHDR;
                        if (idx < idn)
                            ident_acc = {ident_acc[23:0], b};
                        else if (idx < 2 * idn)
                            size_acc = v22 ? {8'h00, size_acc[15:0], b} : size_byte(size_acc, b);
                        fhdr_idx = idx + 4'd1;
                        if (fhdr_idx >= hlen)
                        begin
                            room = 32'(tag_len) - 32'(body_pos) - 32'd1;
                            if (size_acc == 0 || size_acc > room)
                            begin
                                stop  = STOP_BADSIZE;
                                phase = PH_SKIP;
                            end
                            else
                            begin
                                classify();
                                frame_left = size_acc;
                                offset     = '0;
                                phase      = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    r.region         = REG_PAYLOAD;
                    r.frame_class    = cls;
                    r.text_field     = fld;
                    r.frame_ident    = ident_acc;
                    r.payload_offset = offset;
                    r.last_of_frame  = (frame_left == 1);
                    frame_left       = frame_left - 32'd1;
                    offset           = offset + 28'd1;
                    if (frame_left == 0)
                        start_header();
                end
                PH_SKIP:  r.region = REG_SKIP;
                PH_AFTER: r.region = REG_AFTER;
                default:  r.region = REG_NOTAG;
            endcase

            // Close the tag once its last body byte has gone by
            if (in_body)
            begin
                body_pos = body_pos + 28'd1;
                if (body_pos >= tag_len)
                begin
                    if (phase == PH_FHDR && fhdr_idx != 0 && stop == STOP_NONE)
                        stop = STOP_BADSIZE;
                    phase = PH_AFTER;
                end
            end

            r.stop_reason = stop;
            r.tag_version = version;
            return r;
        endfunction

        function void note_byte(logic [7:0] b, logic mark);
            walk_results_q.push_back(walk_byte(b, mark));
        endfunction

        function int unsigned pending();
            return walk_results_q.size();
        endfunction

        function void report(string what, id3fw_out_t want, id3fw_out_t got);
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("result %0d: %s", checked, what);
                $display("  exp region=%0d class=%0d field=%0d id=%h off=%0d last=%0d stop=%0d ver=%h",
                         want.region, want.frame_class, want.text_field, want.frame_ident,
                         want.payload_offset, want.last_of_frame, want.stop_reason,
                         want.tag_version);
                $display("  got region=%0d class=%0d field=%0d id=%h off=%0d last=%0d stop=%0d ver=%h",
                         got.region, got.frame_class, got.text_field, got.frame_ident,
                         got.payload_offset, got.last_of_frame, got.stop_reason,
                         got.tag_version);
            end
        endfunction

        function void check_result(id3fw_out_t got);
            id3fw_out_t want;
            checked++;
            if (walk_results_q.size() == 0)
            begin
                report("no byte request waiting", '0, got);
                return;
            end
            want = walk_results_q.pop_front();
            if (got.region !== want.region || got.frame_class !== want.frame_class ||
                got.text_field !== want.text_field || got.frame_ident !== want.frame_ident ||
                got.payload_offset !== want.payload_offset ||
                got.last_of_frame !== want.last_of_frame ||
                got.stop_reason !== want.stop_reason || got.tag_version !== want.tag_version)
                report("field mismatch", want, got);
        endfunction

    endclass

endpackage

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - testbench for id3v2_frame_walker_core
// Streams byte requests into the walker: a few hand-built headers, then
// random ID3v2 tags (v2.2, v2.3, v2.4 and odd versions, extended headers,
// frames, padding, bad sizes, truncated tags) mixed with broken headers and
// noise. Both channels idle at random. Every result is checked against the
// scoreboard's own walk of the same bytes.
// ----------------------------------------------------------------------------
module tb_top;

    import id3fw_pkg::*;
    import id3fw_walk_sb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned BYTE_TARGET = 1850;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    id3fw_in_t  byte_data  = '0;
    logic       res_valid;
    logic       res_stall  = 1'b0;
    id3fw_out_t res_data;

    id3_walk_scoreboard sb;
    int unsigned        sent   = 0;
    int unsigned        cycles = 0;

    id3v2_frame_walker_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    always #5 clk = ~clk;

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Check each accepted result, then stall at random outside the calm stretch
    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
            sb.check_result(res_data);
        res_stall <= (sb.checked < 900 || sb.checked >= 1300) && ($urandom_range(0, 99) < 11);
    end

    // Offer one byte request, idling first at random, and hold it until taken
    task automatic send_byte(input logic [7:0] value, input logic mark);
        while (!(sent >= 900 && sent < 1300) && $urandom_range(0, 99) < 11)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= '{data_byte: value, first: mark};
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        sb.note_byte(value, mark);
        sent++;
    endtask

    // Part k (from the least significant) of a size field
    function automatic logic [7:0] size_part(logic [7:0] ver, logic [31:0] val, int k);
        if (ver == VER_V24)
            return 8'((val >> (7 * k)) & 32'h7F);
        return 8'(val >> (8 * k));
    endfunction

    function automatic logic [31:0] pick_ident(bit v22);
        logic [31:0] ids4[12] = '{"TIT2", "TPE1", "TALB", "TDRC", "TYER", "TCON",
                                  "TRCK", "TBPM", "TXXX", "APIC", "COMM", "TSSE"};
        logic [23:0] ids3[11] = '{"TT2", "TP1", "TAL", "TYE", "TCO", "TRK",
                                  "TBP", "TXX", "PIC", "COM", "TEN"};
        if ($urandom_range(0, 7) == 0)
            return v22 ? {8'h00, 8'($urandom_range(1, 255)), 16'($urandom)}
                       : {8'($urandom_range(1, 255)), 24'($urandom)};
        if (v22)
            return {8'h00, ids3[$urandom_range(0, 10)]};
        return ids4[$urandom_range(0, 11)];
    endfunction

    // Build one tag with random content, send it and a few bytes after it
    task automatic send_file(input bit broken);
        logic [7:0]  body[$];
        logic [7:0]  hdr[10];
        logic [7:0]  ver;
        logic [31:0] fid;
        logic [31:0] fsz;
        int unsigned pick;
        int unsigned flags;
        int unsigned esz;
        int unsigned fill;
        int unsigned nfr;
        int unsigned tlen;
        int unsigned cut;
        bit          v22;

        pick  = $urandom_range(0, 9);
        ver   = (pick < 3) ? VER_V22 : (pick < 6) ? VER_V23 :
                (pick < 9) ? VER_V24 : 8'($urandom_range(0, 255));
        v22   = (ver == VER_V22);
        flags = $urandom_range(0, 255) & ~32'h40;

        // Extended header: four size bytes and the bytes it covers
        if (ver >= VER_V23 && $urandom_range(0, 3) == 0)
        begin
            flags = flags | 32'h40;
            esz   = $urandom_range(0, 10);
            for (int k = 3; k >= 0; k--)
                body.push_back(size_part(ver, esz, k));
            fill = (ver == VER_V24) ? ((esz > 4) ? esz - 4 : 0) : esz;
            repeat (fill) body.push_back(8'($urandom));
        end

        // Frames, now and then with a zero or oversized size field
        nfr = $urandom_range(0, 5);
        repeat (nfr)
        begin
            fid  = pick_ident(v22);
            fsz  = $urandom_range(1, 12);
            fill = fsz;
            case ($urandom_range(0, 15))
                0: fsz = 0;
                1:
                begin
                    fsz  = $urandom | 32'h0010_0000;
                    fill = 3;
                end
                default: ;
            endcase
            if (v22)
            begin
                for (int k = 2; k >= 0; k--)
                    body.push_back(fid[8 * k +: 8]);
                for (int k = 2; k >= 0; k--)
                    body.push_back(size_part(VER_V23, fsz, k));
            end
            else
            begin
                for (int k = 3; k >= 0; k--)
                    body.push_back(fid[8 * k +: 8]);
                for (int k = 3; k >= 0; k--)
                    body.push_back(size_part(ver, fsz, k));
                repeat (2) body.push_back(8'($urandom));
            end
            repeat (fill) body.push_back(8'($urandom));
        end

        // Padding
        if ($urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, 8)) body.push_back(8'h00);

        // Tag size: mostly exact, sometimes short or long
        tlen = body.size();
        case ($urandom_range(0, 7))
            0:
            begin
                cut  = $urandom_range(1, 6);
                tlen = (tlen > cut) ? tlen - cut : 0;
            end
            1: tlen = tlen + $urandom_range(1, 6);
            default: ;
        endcase

        hdr[0] = MAGIC_0;
        hdr[1] = MAGIC_1;
        hdr[2] = MAGIC_2;
        hdr[3] = ver;
        hdr[4] = 8'($urandom);
        hdr[5] = 8'(flags);
        for (int k = 0; k < 4; k++)
            hdr[9 - k] = size_part(VER_V24, tlen, k) | {$urandom_range(0, 1) == 1, 7'h00};
        if (broken)
            hdr[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));

        for (int i = 0; i < 10; i++)
            send_byte(hdr[i], i == 0);
        foreach (body[i])
            send_byte(body[i], 1'b0);
        repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0);
    endtask

    initial
    begin
        int unsigned files;
        files = 0;
        sb    = new();

        // Hold reset at the start, once
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes before any start-of-file mark
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        // v2.4 header with every flag and size bit set, then a full extended size
        send_byte(MAGIC_0, 1'b1);
        send_byte(MAGIC_1, 1'b0);
        send_byte(MAGIC_2, 1'b0);
        send_byte(VER_V24, 1'b0);
        repeat (6) send_byte(8'hFF, 1'b0);
        repeat (5) send_byte(8'hFF, 1'b0);

        // Zero tag size, then one byte after the tag
        send_byte(MAGIC_0, 1'b1);
        send_byte(MAGIC_1, 1'b0);
        send_byte(MAGIC_2, 1'b0);
        send_byte(VER_V23, 1'b0);
        repeat (6) send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);

        // Bad magic on the third byte
        send_byte(MAGIC_0, 1'b1);
        send_byte(MAGIC_1, 1'b0);
        send_byte(8'h58, 1'b0);

        // Random tags, broken headers and noise
        while (sent < BYTE_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
            else
            begin
                send_file($urandom_range(0, 7) == 0);
                files++;
            end
            // Once, let the walker drain completely before going on
            if (files == 6)
            begin
                byte_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                begin
                    @(posedge clk);
                end
                files++;
            end
        end
        byte_valid <= 1'b0;

        // Drain, then wait for any stray result
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (sb.fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
